// File: src/sfd_pkg.sv
// Shared constants, types and saturation helper for the stereo feedback delay.
// No dependencies; imported by sfd_lane, stereo_feedback_delay and the testbench.
package sfd_pkg;

  localparam int LINE_DEPTH  = 65536;               // power of two
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_BITS = 24;

  localparam int DELAY_W  = 16;
  localparam int SPREAD_W = 15;
  localparam int GAIN_W   = 15;
  localparam int MIX_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int Q_FRAC   = 15;
  localparam int RND_HALF = 16384;
  localparam logic [MIX_W-1:0] MIX_UNITY = 16'h8000;

  localparam logic [DELAY_W-1:0]  DELAY_RST  = 16'd11202;
  localparam logic [SPREAD_W-1:0] SPREAD_RST = 15'd0;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 15'd12207;
  localparam logic [MIX_W-1:0]    MIX_RST    = 16'd10280;

  // widest intermediate: two 17-bit-scaled products summed
  localparam int SAT_W = SAMPLE_BITS + 18;
  localparam logic signed [SAT_W-1:0] SAT_HI =
    $signed({{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] SAT_LO =
    $signed({{(SAT_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY  = 2'd0,
    CFG_SPREAD = 2'd1,
    CFG_GAIN   = 2'd2,
    CFG_MIX    = 2'd3
  } sfd_cfg_e;

  typedef struct packed {
    logic               accept;
    logic               adv;
    logic               s1_valid;
    logic               s2_valid;
    logic [LINE_AW-1:0] wr_ptr;
  } sfd_ctrl_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/sfd_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sfd_lane.sv
// One channel of the delay: line memory, tap forwarding, feedback and mix math.
// Depends on sfd_pkg and sfd_ram.
module sfd_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sfd_pkg::sfd_ctrl_t                    ctrl_i,
  input  logic [sfd_pkg::LINE_AW-1:0]           rd_addr_i,
  input  logic                                  tap_ok_i,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [sfd_pkg::GAIN_W-1:0]            gain_i,
  input  logic [sfd_pkg::MIX_W-1:0]             mix_i,
  input  logic [sfd_pkg::MIX_W-1:0]             dry_i,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] result_o
);
  import sfd_pkg::*;

  localparam int PF_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int PM_W = SAMPLE_BITS + MIX_W + 1;

  logic [SAMPLE_BITS-1:0]        rdata;
  logic                          ram_we;

  logic signed [SAMPLE_BITS-1:0] x_s1_q, x_s2_q;
  logic [LINE_AW-1:0]            wp_s1_q, wp_s2_q, ra_s1_q;
  logic                          ok_s1_q;

  logic signed [SAMPLE_BITS-1:0] tap;
  logic signed [PF_W-1:0]        p_fb_d, p_fb_q;
  logic signed [PM_W-1:0]        p_dry_d, p_dry_q, p_wet_d, p_wet_q;

  logic signed [PF_W-1:0]        fb_rnd, fb;
  logic signed [SAT_W-1:0]       acc, acc_sh;
  logic signed [SAMPLE_BITS-1:0] wr_val;

  logic                          lw_valid_q;
  logic [LINE_AW-1:0]            lw_addr_q;
  logic signed [SAMPLE_BITS-1:0] lw_data_q;

  assign ram_we = ctrl_i.adv && ctrl_i.s2_valid;

  sfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_s2_q),
    .wdata_i (wr_val),
    .re_i    (ctrl_i.accept),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // Tap select: pending write in S2, then the last write (read-first RAM),
  // then the RAM; entries never written read as zero.
  always_comb begin
    if (ctrl_i.s2_valid && (wp_s2_q == ra_s1_q)) begin
      tap = wr_val;
    end else if (lw_valid_q && (lw_addr_q == ra_s1_q)) begin
      tap = lw_data_q;
    end else if (ok_s1_q) begin
      tap = $signed(rdata);
    end else begin
      tap = '0;
    end
  end

  assign p_fb_d  = tap * $signed({1'b0, gain_i});
  assign p_dry_d = x_s1_q * $signed({1'b0, dry_i});
  assign p_wet_d = tap * $signed({1'b0, mix_i});

  assign fb_rnd = p_fb_q + PF_W'(RND_HALF);
  assign fb     = fb_rnd >>> Q_FRAC;
  assign wr_val = sat_sample(SAT_W'(x_s2_q) + SAT_W'(fb));

  assign acc      = SAT_W'(p_dry_q) + SAT_W'(p_wet_q) + SAT_W'(RND_HALF);
  assign acc_sh   = acc >>> Q_FRAC;
  assign result_o = sat_sample(acc_sh);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_s1_q  <= sample_i;
      wp_s1_q <= ctrl_i.wr_ptr;
      ra_s1_q <= rd_addr_i;
      ok_s1_q <= tap_ok_i;
    end
    if (ctrl_i.adv && ctrl_i.s1_valid) begin
      x_s2_q  <= x_s1_q;
      wp_s2_q <= wp_s1_q;
      p_fb_q  <= p_fb_d;
      p_dry_q <= p_dry_d;
      p_wet_q <= p_wet_d;
    end
    if (ram_we) begin
      lw_addr_q <= wp_s2_q;
      lw_data_q <= wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (ram_we) begin
      lw_valid_q <= 1'b1;
    end
  end

endmodule

// File: src/stereo_feedback_delay.sv
// Stereo feedback delay top level: config registers, write pointer, read
// address generation and pipeline control. Depends on sfd_pkg and sfd_lane.
//
// Takes one stereo pair per clock and returns one mixed pair per clock;
// a result passes through the S1, S2 and output registers, and the
// pipeline only holds while the output is stalled. Each line memory has
// one read and one write port, which sets the rate at one pair per cycle.
// Writes still in flight are forwarded to the taps. There is no clearing
// pass after reset: a fill flag on the write pointer makes every entry
// not yet written read as zero, so the block is ready at once.
// Configuration is meant to change only while the block is idle.
module stereo_feedback_delay (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sfd_pkg::CFG_W-1:0]              cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] in_left_i,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] in_right_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] out_left_o,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] out_right_o
);
  import sfd_pkg::*;

  localparam int CW = ((LINE_AW > DELAY_W) ? LINE_AW : DELAY_W) + 1;

  logic [DELAY_W-1:0]  delay_q,  delay_d;
  logic [SPREAD_W-1:0] spread_q, spread_d;
  logic [GAIN_W-1:0]   gain_q,   gain_d;
  logic [MIX_W-1:0]    mix_q,    mix_d;

  logic [LINE_AW-1:0]  wp_q, wp_d;
  logic                wrapped_q, wrapped_d;
  logic                s1_valid_q, s1_valid_d;
  logic                s2_valid_q, s2_valid_d;
  logic                out_valid_q, out_valid_d;

  logic [CW-1:0]       d_ext, d_cl_w, half_w, sp_ext, sp_cl_w;
  logic [LINE_AW-1:0]  rd_left, rd_right;
  logic                ok_left, ok_right;
  logic [MIX_W-1:0]    mix_cl, dry;

  logic                stall, adv, accept;
  sfd_ctrl_t           ctrl;

  logic signed [SAMPLE_BITS-1:0] res_left, res_right;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

  // config writes
  always_comb begin
    delay_d  = delay_q;
    spread_d = spread_q;
    gain_d   = gain_q;
    mix_d    = mix_q;
    if (cfg_we_i) begin
      case (sfd_cfg_e'(cfg_index_i))
        CFG_DELAY:  delay_d  = cfg_data_i[DELAY_W-1:0];
        CFG_SPREAD: spread_d = cfg_data_i[SPREAD_W-1:0];
        CFG_GAIN:   gain_d   = cfg_data_i[GAIN_W-1:0];
        CFG_MIX:    mix_d    = cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamps and tap addresses
  always_comb begin
    d_ext = CW'(delay_q);
    if (d_ext == '0) begin
      d_cl_w = CW'(1);
    end else if (d_ext > CW'(LINE_DEPTH - 1)) begin
      d_cl_w = CW'(LINE_DEPTH - 1);
    end else begin
      d_cl_w = d_ext;
    end
    half_w  = d_cl_w >> 1;
    sp_ext  = CW'(spread_q);
    sp_cl_w = (sp_ext > half_w) ? half_w : sp_ext;

    rd_left  = wp_q - d_cl_w[LINE_AW-1:0];
    rd_right = rd_left - sp_cl_w[LINE_AW-1:0];
    ok_left  = wrapped_q || (rd_left < wp_q);
    ok_right = wrapped_q || (rd_right < wp_q);

    mix_cl = (mix_q > MIX_UNITY) ? MIX_UNITY : mix_q;
    dry    = MIX_UNITY - mix_cl;
  end

  // pipeline control
  assign stall      = out_valid_q && !out_ready_i;
  assign adv        = !stall;
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;

  assign ctrl.accept   = accept;
  assign ctrl.adv      = adv;
  assign ctrl.s1_valid = s1_valid_q;
  assign ctrl.s2_valid = s2_valid_q;
  assign ctrl.wr_ptr   = wp_q;

  always_comb begin
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    s1_valid_d  = s1_valid_q;
    s2_valid_d  = s2_valid_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      wp_d = wp_q + 1'b1;
      if (wp_q == '1) begin
        wrapped_d = 1'b1;
      end
    end
    if (adv) begin
      s1_valid_d  = accept;
      s2_valid_d  = s1_valid_q;
      out_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= DELAY_RST;
      spread_q    <= SPREAD_RST;
      gain_q      <= GAIN_RST;
      mix_q       <= MIX_RST;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      delay_q     <= delay_d;
      spread_q    <= spread_d;
      gain_q      <= gain_d;
      mix_q       <= mix_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  sfd_lane u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_left),
    .tap_ok_i  (ok_left),
    .sample_i  (in_left_i),
    .gain_i    (gain_q),
    .mix_i     (mix_cl),
    .dry_i     (dry),
    .result_o  (res_left)
  );

  sfd_lane u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_right),
    .tap_ok_i  (ok_right),
    .sample_i  (in_right_i),
    .gain_i    (gain_q),
    .mix_i     (mix_cl),
    .dry_i     (dry),
    .result_o  (res_right)
  );

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_left_q  <= res_left;
      out_right_q <= res_right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

endmodule

// File: tb/sv/stereo_feedback_delay_tb.sv
// Testbench for stereo_feedback_delay: directed and random stereo pairs under
// random idling and back-pressure, each result checked against an echo predictor.
// Depends on sfd_pkg and the stereo_feedback_delay RTL.
module stereo_feedback_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct {
    sample_t out_l;
    sample_t out_r;
  } stereo_pair_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  sfd_cfg_e         cfg_index = CFG_DELAY;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  sample_t          in_left = '0;
  sample_t          in_right = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  sample_t          out_left;
  sample_t          out_right;

  // predictor state
  sample_t             left_echo_mem  [LINE_DEPTH];
  sample_t             right_echo_mem [LINE_DEPTH];
  logic [LINE_AW-1:0]  echo_wr_ptr;
  logic [DELAY_W-1:0]  delay_m;
  logic [SPREAD_W-1:0] spread_m;
  logic [GAIN_W-1:0]   gain_m;
  logic [MIX_W-1:0]    mix_m;
  stereo_pair_t        mixed_pairs_q[$];

  int n_errors     = 0;
  int quiet_cycles = 0;
  int burst_left   = 1;
  int tx_gap_max   = 6;
  int rx_mode      = 1;
  bit long_hold_req = 1'b0;

  stereo_feedback_delay dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_left_i   (in_left),
    .in_right_i  (in_right),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_left_o  (out_left),
    .out_right_o (out_right)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sample_t clip_sample(input longint v);
    if (v > SAMPLE_HI) return S_MAX;
    if (v < SAMPLE_LO) return S_MIN;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // floor((p + half) / 2^15)
  function automatic longint round_q15(input longint p);
    return (p + longint'(RND_HALF)) >>> Q_FRAC;
  endfunction

  function automatic void reset_echo_model();
    foreach (left_echo_mem[i]) begin
      left_echo_mem[i]  = '0;
      right_echo_mem[i] = '0;
    end
    echo_wr_ptr = '0;
    delay_m     = DELAY_RST;
    spread_m    = SPREAD_RST;
    gain_m      = GAIN_RST;
    mix_m       = MIX_RST;
  endfunction

  function automatic void predict_echo_mix(input sample_t left_in, input sample_t right_in);
    int d, sp, m, wp, rl, rr;
    longint xl, xr, tl, tr, g, wet, dry;
    stereo_pair_t res;
    d  = int'(delay_m);
    sp = int'(spread_m);
    m  = int'(mix_m);
    if (d < 1) d = 1;
    if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
    if (sp > d / 2) sp = d / 2;
    if (m > 32768) m = 32768;
    wp = int'(echo_wr_ptr);
    rl = (wp + LINE_DEPTH - d) % LINE_DEPTH;
    rr = (wp + 2 * LINE_DEPTH - d - sp) % LINE_DEPTH;
    xl  = left_in;
    xr  = right_in;
    tl  = left_echo_mem[rl];
    tr  = right_echo_mem[rr];
    g   = longint'(gain_m);
    wet = m;
    dry = 32768 - m;
    left_echo_mem[wp]  = clip_sample(xl + round_q15(tl * g));
    right_echo_mem[wp] = clip_sample(xr + round_q15(tr * g));
    echo_wr_ptr = echo_wr_ptr + 1'b1;
    res.out_l = clip_sample(round_q15(xl * dry + tl * wet));
    res.out_r = clip_sample(round_q15(xr * dry + tr * wet));
    mixed_pairs_q.push_back(res);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'($urandom_range(0, 63) - 32);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic check_field(input string name, input sample_t want, input sample_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // leaves valid high after the transfer unless a burst ends with tx_gap_max above zero
  task automatic send_pair(input sample_t l, input sample_t r);
    in_valid <= 1'b1;
    in_left  <= l;
    in_right <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_echo_mix(l, r);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = int'($urandom_range(1, 24));
      if (tx_gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (mixed_pairs_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input sfd_cfg_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_DELAY:  delay_m  = val[DELAY_W-1:0];
      CFG_SPREAD: spread_m = val[SPREAD_W-1:0];
      CFG_GAIN:   gain_m   = val[GAIN_W-1:0];
      CFG_MIX:    mix_m    = val[MIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_set(input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] spr,
                         input logic [CFG_W-1:0] gn, input logic [CFG_W-1:0] mx);
    cfg_write(CFG_DELAY, dly);
    cfg_write(CFG_SPREAD, spr);
    cfg_write(CFG_GAIN, gn);
    cfg_write(CFG_MIX, mx);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_random();
    logic [CFG_W-1:0] dly, spr, gn, mx;
    case ($urandom_range(0, 5))
      0: dly = CFG_W'($urandom());
      1: dly = CFG_W'($urandom_range(0, 2));
      default: dly = CFG_W'($urandom_range(1, 48));
    endcase
    spr = ($urandom_range(0, 2) == 0) ? CFG_W'($urandom()) : CFG_W'($urandom_range(0, 24));
    gn  = CFG_W'($urandom());
    case ($urandom_range(0, 5))
      0: mx = MIX_UNITY;
      1: mx = '0;
      2: mx = CFG_W'($urandom());
      default: mx = CFG_W'($urandom_range(0, 32768));
    endcase
    cfg_set(dly, spr, gn, mx);
  endtask

  task automatic test_reset_defaults();
    rx_mode = 1;
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    send_pair(sample_t'(24'hAAAAAA), sample_t'(24'h555555));
    wait_drain();
  endtask

  // zero delay, oversized spread, full gain, mix above unity: stores saturate
  task automatic test_clamps_saturation();
    cfg_set(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_pair(S_MAX, S_MIN);
    repeat (3) send_pair(S_MIN, S_MAX);
    wait_drain();
  endtask

  // longest delay and spread: right tap address wraps past the line depth
  task automatic test_long_wrap();
    cfg_set(16'hFFFF, 16'h7FFF, 16'd0, 16'd0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(rand_sample(), rand_sample());
    send_pair(rand_sample(), rand_sample());
    wait_drain();
  endtask

  task automatic test_ping_pong();
    cfg_set(16'd4, 16'd2, 16'd31130, 16'd16384);
    send_pair(S_MAX, S_MIN);
    send_pair('0, '0);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair('0, '0);
    send_pair('0, '0);
    wait_drain();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 13; ph++) begin
      rx_mode    = (ph % 3 == 0) ? 0 : 1;
      tx_gap_max = (ph % 4 == 1) ? 0 : 6;
      cfg_random();
      repeat (80) send_pair(rand_sample(), rand_sample());
      wait_drain();
    end
    tx_gap_max = 6;
    rx_mode    = 1;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    cfg_set(16'd3, 16'd1, 16'd30000, 16'd20000);
    tx_gap_max    = 0;
    long_hold_req = 1'b1;
    repeat (80) send_pair(rand_sample(), rand_sample());
    tx_gap_max = 6;
    wait_drain();
  endtask

  initial begin : rx_side
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_mode == 0) begin
        out_ready <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        out_ready <= !out_ready;
        run = out_ready ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 9));
      end
    end
  end

  always @(posedge clk) begin
    stereo_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mixed_pairs_q.size() == 0) begin
        $error("unexpected transfer: out_left %0d, out_right %0d", out_left, out_right);
        n_errors++;
      end else begin
        want = mixed_pairs_q.pop_front();
        check_field("out_left", want.out_l, out_left);
        check_field("out_right", want.out_r, out_right);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stereo_feedback_delay_tb: done, errors");
      $finish;
    end
  end

  initial begin
    reset_echo_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_clamps_saturation();
    test_long_wrap();
    test_ping_pong();
    test_random_settings();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("stereo_feedback_delay_tb: done, clean");
    end else begin
      $display("stereo_feedback_delay_tb: done, errors");
    end
    $finish;
  end

endmodule
